### rtl/core/pwlcr_pkg.sv
// Package for the piecewise linear color ramp core.
// Holds widths, register indexes, the sequencer state type and the divider status struct.
// No dependencies.
package pwlcr_pkg;

   localparam int MAX_STOPS  = 7;
   localparam int STOP_IDX_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int POS_W      = 32;
   localparam int COLOR_W    = 32;
   localparam int STOP_W     = POS_W + COLOR_W;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int CH_IDX_W   = 2;
   localparam int PROD_W     = CH_W + POS_W;
   localparam int DIVIDEND_W = PROD_W + 2;
   localparam int DIVISOR_W  = POS_W + 1;
   localparam int QUOT_W     = CH_W + 1;
   localparam int DIV_CNT_W  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_FIRST = 3'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SEARCH,
      S_MUL,
      S_PREP,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_status_type;

endpackage

### rtl/core/piecewise_linear_color_ramp_core.sv
// Top level of the piecewise linear color ramp: stop registers, search sequencer, blend.
// Depends on pwlcr_pkg and pwlcr_div.
//
//  channel   ports                                   transfer when
//  request   start, busy, req_sample_*               start high and busy low
//  response  rsp_strobe, rsp_ramp_color_out,         rsp_strobe high, one cycle
//            rsp_color_valid
//  csr       csr_wr_en, csr_index, csr_wdata         csr_wr_en high
//
// An item that is absent or has fewer than two stops goes straight to the strobe.
// Otherwise the first and last stop checks run; a sample between the end stops then
// takes a search over the inner stops and, per color byte, a multiply, a prepare step
// and the 9-step shared divider. Busy drops the cycle after the strobe.
// Reset clears the stops and the sequencer. The receiver cannot stall.
module piecewise_linear_color_ramp_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [pwlcr_pkg::POS_W-1:0]  req_sample_value,
   input  logic                                req_sample_present,
   output logic                                rsp_strobe,
   output logic [pwlcr_pkg::COLOR_W-1:0]       rsp_ramp_color_out,
   output logic                                rsp_color_valid,
   input  logic                                csr_wr_en,
   input  logic [pwlcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pwlcr_pkg::STOP_W-1:0]        csr_wdata
);

   pwlcr_pkg::state_type state_ff, state_in;

   logic [pwlcr_pkg::STOP_W-1:0]          stop_ff [pwlcr_pkg::MAX_STOPS];
   logic [pwlcr_pkg::STOP_IDX_W-1:0]      stop_count_ff;

   logic signed [pwlcr_pkg::POS_W-1:0]    value_ff, value_in;
   logic [pwlcr_pkg::STOP_IDX_W-1:0]      n_ff, n_in;
   logic [pwlcr_pkg::STOP_IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic signed [pwlcr_pkg::POS_W-1:0]    lo_pos_ff, lo_pos_in;
   logic [pwlcr_pkg::COLOR_W-1:0]         lo_color_ff, lo_color_in;
   logic [pwlcr_pkg::COLOR_W-1:0]         hi_color_ff, hi_color_in;
   logic [pwlcr_pkg::POS_W-1:0]           num_ff, num_in;
   logic [pwlcr_pkg::POS_W-1:0]           den_ff, den_in;
   logic [pwlcr_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic                                  neg_ff, neg_in;
   logic                                  flip_ff, flip_in;
   logic [pwlcr_pkg::CH_IDX_W-1:0]        ch_ff, ch_in;
   logic [pwlcr_pkg::COLOR_W-1:0]         result_ff, result_in;
   logic                                  valid_ff, valid_in;

   logic [pwlcr_pkg::STOP_W-1:0]          stop_rd;
   logic signed [pwlcr_pkg::POS_W-1:0]    rd_pos;
   logic [pwlcr_pkg::COLOR_W-1:0]         rd_color;
   logic signed [pwlcr_pkg::POS_W:0]      span;
   logic signed [pwlcr_pkg::POS_W:0]      offset;
   logic [4:0]                            byte_sel;
   logic [pwlcr_pkg::CH_W-1:0]            s_byte;
   logic [pwlcr_pkg::CH_W-1:0]            e_byte;
   logic signed [pwlcr_pkg::DIVIDEND_W:0] numer;
   logic [pwlcr_pkg::DIVIDEND_W-1:0]      div_dividend;
   logic [pwlcr_pkg::DIVISOR_W-1:0]       div_divisor;
   logic                                  div_load;
   pwlcr_pkg::div_status_type             div_stat;
   logic                                  accept;

   assign accept   = start && !busy;
   assign stop_rd  = stop_ff[rd_idx_ff];
   assign rd_pos   = stop_rd[pwlcr_pkg::STOP_W-1:pwlcr_pkg::COLOR_W];
   assign rd_color = stop_rd[pwlcr_pkg::COLOR_W-1:0];
   assign span     = {rd_pos[pwlcr_pkg::POS_W-1], rd_pos}
                   - {lo_pos_ff[pwlcr_pkg::POS_W-1], lo_pos_ff};
   assign offset   = {value_ff[pwlcr_pkg::POS_W-1], value_ff}
                   - {lo_pos_ff[pwlcr_pkg::POS_W-1], lo_pos_ff};
   assign byte_sel = {ch_ff, 3'b000};
   assign s_byte   = lo_color_ff[byte_sel +: pwlcr_pkg::CH_W];
   assign e_byte   = hi_color_ff[byte_sel +: pwlcr_pkg::CH_W];

   assign numer = neg_ff
      ? ($signed({11'b0, den_ff}) - $signed({2'b0, prod_ff, 1'b0}))
      : ($signed({2'b0, prod_ff, 1'b0}) + $signed({11'b0, den_ff}));
   assign div_dividend = numer[pwlcr_pkg::DIVIDEND_W]
      ? ~numer[pwlcr_pkg::DIVIDEND_W-1:0] : numer[pwlcr_pkg::DIVIDEND_W-1:0];
   assign div_divisor  = {den_ff, 1'b0};

   pwlcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pwlcr_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (req_sample_present && stop_count_ff >= 3'd2)
                        ? pwlcr_pkg::S_FIRST : pwlcr_pkg::S_DONE;
            end
         end
         pwlcr_pkg::S_FIRST: begin
            state_in = (value_ff <= rd_pos) ? pwlcr_pkg::S_DONE : pwlcr_pkg::S_LAST;
         end
         pwlcr_pkg::S_LAST: begin
            state_in = (value_ff >= rd_pos) ? pwlcr_pkg::S_DONE : pwlcr_pkg::S_SEARCH;
         end
         pwlcr_pkg::S_SEARCH: begin
            if (value_ff <= rd_pos) begin
               state_in = (span[pwlcr_pkg::POS_W] || span == '0)
                        ? pwlcr_pkg::S_DONE : pwlcr_pkg::S_MUL;
            end
         end
         pwlcr_pkg::S_MUL:  state_in = pwlcr_pkg::S_PREP;
         pwlcr_pkg::S_PREP: state_in = pwlcr_pkg::S_DIV;
         pwlcr_pkg::S_DIV: begin
            if (div_stat.done) begin
               state_in = (ch_ff == pwlcr_pkg::CH_IDX_W'(pwlcr_pkg::NUM_CH - 1))
                        ? pwlcr_pkg::S_DONE : pwlcr_pkg::S_MUL;
            end
         end
         pwlcr_pkg::S_DONE: state_in = pwlcr_pkg::S_IDLE;
         default:           state_in = pwlcr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      busy       = (state_ff != pwlcr_pkg::S_IDLE);
      rsp_strobe = (state_ff == pwlcr_pkg::S_DONE);
      div_load   = (state_ff == pwlcr_pkg::S_PREP);
   end

   always_comb begin
      value_in    = value_ff;
      n_in        = n_ff;
      rd_idx_in   = rd_idx_ff;
      lo_pos_in   = lo_pos_ff;
      lo_color_in = lo_color_ff;
      hi_color_in = hi_color_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      prod_in     = prod_ff;
      neg_in      = neg_ff;
      flip_in     = flip_ff;
      ch_in       = ch_ff;
      result_in   = result_ff;
      valid_in    = valid_ff;
      unique case (state_ff)
         pwlcr_pkg::S_IDLE: begin
            if (accept) begin
               value_in  = req_sample_value;
               n_in      = stop_count_ff;
               rd_idx_in = '0;
               result_in = '0;
               valid_in  = req_sample_present && stop_count_ff >= 3'd2;
            end
         end
         pwlcr_pkg::S_FIRST: begin
            if (value_ff <= rd_pos) begin
               result_in = rd_color;
            end else begin
               lo_pos_in   = rd_pos;
               lo_color_in = rd_color;
               rd_idx_in   = n_ff - 1'b1;
            end
         end
         pwlcr_pkg::S_LAST: begin
            if (value_ff >= rd_pos) begin
               result_in = rd_color;
            end else begin
               rd_idx_in = 3'd1;
            end
         end
         pwlcr_pkg::S_SEARCH: begin
            if (value_ff > rd_pos) begin
               lo_pos_in   = rd_pos;
               lo_color_in = rd_color;
               rd_idx_in   = rd_idx_ff + 1'b1;
            end else if (span[pwlcr_pkg::POS_W] || span == '0) begin
               result_in = lo_color_ff;
            end else begin
               hi_color_in = rd_color;
               num_in      = offset[pwlcr_pkg::POS_W-1:0];
               den_in      = span[pwlcr_pkg::POS_W-1:0];
               ch_in       = '0;
               result_in   = '0;
            end
         end
         pwlcr_pkg::S_MUL: begin
            neg_in  = (e_byte < s_byte);
            prod_in = (e_byte < s_byte) ? (s_byte - e_byte) * num_ff
                                        : (e_byte - s_byte) * num_ff;
         end
         pwlcr_pkg::S_PREP: begin
            flip_in = numer[pwlcr_pkg::DIVIDEND_W];
         end
         pwlcr_pkg::S_DIV: begin
            if (div_stat.done) begin
               result_in[byte_sel +: pwlcr_pkg::CH_W] = s_byte
                  + (flip_ff ? ~div_stat.quot[pwlcr_pkg::CH_W-1:0]
                             : div_stat.quot[pwlcr_pkg::CH_W-1:0]);
               ch_in = ch_ff + 1'b1;
            end
         end
         pwlcr_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pwlcr_pkg::S_IDLE;
         stop_count_ff <= '0;
         for (int i = 0; i < pwlcr_pkg::MAX_STOPS; i++) begin
            stop_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            if (csr_index == pwlcr_pkg::CSR_STOP_COUNT) begin
               stop_count_ff <= csr_wdata[pwlcr_pkg::STOP_IDX_W-1:0];
            end else begin
               stop_ff[csr_index - pwlcr_pkg::CSR_STOP_FIRST] <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      n_ff        <= n_in;
      rd_idx_ff   <= rd_idx_in;
      lo_pos_ff   <= lo_pos_in;
      lo_color_ff <= lo_color_in;
      hi_color_ff <= hi_color_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      flip_ff     <= flip_in;
      ch_ff       <= ch_in;
      result_ff   <= result_in;
      valid_ff    <= valid_in;
   end

   assign rsp_ramp_color_out = result_ff;
   assign rsp_color_valid    = valid_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after request transfer");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_color_valid |-> rsp_ramp_color_out == '0)
      else $error("invalid response carries a nonzero color");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == pwlcr_pkg::S_DIV)
      else $error("divider finished outside the divide step");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == pwlcr_pkg::S_SEARCH |-> rd_idx_ff < n_ff)
      else $error("stop search ran past the last stop");
`endif

endmodule

### rtl/core/pwlcr_div.sv
// Restoring divider for the color ramp, one quotient bit per cycle.
// Depends on pwlcr_pkg.
module pwlcr_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [pwlcr_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [pwlcr_pkg::DIVISOR_W-1:0]     divisor,
   output pwlcr_pkg::div_status_type           status
);

   logic [pwlcr_pkg::DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [pwlcr_pkg::DIVIDEND_W-1:0] dsr_ff, dsr_in;
   logic [pwlcr_pkg::QUOT_W-1:0]     quot_ff, quot_in;
   logic [pwlcr_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                             active_ff, active_in;
   logic                             done_ff, done_in;
   logic                             ge;

   assign ge = (rem_ff >= dsr_ff);

   always_comb begin
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (load) begin
         rem_in    = dividend;
         dsr_in    = pwlcr_pkg::DIVIDEND_W'({divisor, {(pwlcr_pkg::QUOT_W-1){1'b0}}});
         quot_in   = '0;
         cnt_in    = pwlcr_pkg::DIV_CNT_W'(pwlcr_pkg::QUOT_W - 1);
         active_in = 1'b1;
      end else if (active_ff) begin
         rem_in  = ge ? (rem_ff - dsr_ff) : rem_ff;
         dsr_in  = dsr_ff >> 1;
         quot_in = {quot_ff[pwlcr_pkg::QUOT_W-2:0], ge};
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign status.done = done_ff;
   assign status.quot = quot_ff;

endmodule
